[sv/vct_pkg.sv]
// ----------------------------------------------------------------------------
// vct_pkg
// Shared types, register indexes and mode decoding for the viewport camera
// transform.
// ----------------------------------------------------------------------------
package vct_pkg;

  typedef enum logic [1:0] {
    KIND_S2W_POINT = 2'd0,
    KIND_W2S_POINT = 2'd1,
    KIND_S2W_DELTA = 2'd2,
    KIND_W2S_DELTA = 2'd3
  } kind_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y  = 3'd7;

  localparam logic [31:0] ZOOM_ONE = 32'd65536;
  localparam logic [15:0] COS_ONE  = 16'd16384;

  typedef struct packed {
    logic [31:0]        origin;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [31:0]        zoom;
    logic signed [15:0] rcos;
    logic signed [15:0] rsin;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  invalid;
  } ctl_t;

  function automatic logic is_point(kind_t k);
    return (k == KIND_S2W_POINT) || (k == KIND_W2S_POINT);
  endfunction

  function automatic logic is_inverse(kind_t k);
    return (k == KIND_S2W_POINT) || (k == KIND_S2W_DELTA);
  endfunction

  // Viewport center in half pixels: 2 * origin + size.
  function automatic logic signed [17:0] center_x2(logic [15:0] o, logic [15:0] s);
    return {o[15], o, 1'b0} + {{2{s[15]}}, s};
  endfunction

endpackage

[sv/vct_in_if.sv]
// ----------------------------------------------------------------------------
// vct_in_if
// Input channel: mode and coordinate pair with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vct_in_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;

  modport source(output valid, kind, in_x, in_y, input ready);
  modport sink(input valid, kind, in_x, in_y, output ready);
endinterface

[sv/vct_out_if.sv]
// ----------------------------------------------------------------------------
// vct_out_if
// Output channel: transformed pair and invalid flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vct_out_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic                 invalid;

  modport source(output valid, out_x, out_y, invalid, input ready);
  modport sink(input valid, out_x, out_y, invalid, output ready);
endinterface

[sv/vct_cfg.sv]
// ----------------------------------------------------------------------------
// vct_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module vct_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [vct_pkg::CFG_IDX_W-1:0]    index,
  input  logic [vct_pkg::CFG_DATA_W-1:0]   data,
  output vct_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{origin: '0, width: '0, height: '0, zoom: vct_pkg::ZOOM_ONE,
               rcos: vct_pkg::COS_ONE, rsin: '0, cam_x: '0, cam_y: '0};
    end else if (we) begin
      unique case (index)
        vct_pkg::REG_ORIGIN: cfg.origin <= data;
        vct_pkg::REG_WIDTH:  cfg.width  <= data[15:0];
        vct_pkg::REG_HEIGHT: cfg.height <= data[15:0];
        vct_pkg::REG_ZOOM:   cfg.zoom   <= data;
        vct_pkg::REG_COS:    cfg.rcos   <= data[15:0];
        vct_pkg::REG_SIN:    cfg.rsin   <= data[15:0];
        vct_pkg::REG_CAM_X:  cfg.cam_x  <= data;
        vct_pkg::REG_CAM_Y:  cfg.cam_y  <= data;
        default: ;
      endcase
    end
  end

endmodule

[sv/vct_front.sv]
// ----------------------------------------------------------------------------
// vct_front
// Three-stage front end: offsets, rotation products and rotation sums.
// ----------------------------------------------------------------------------
module vct_front #(
  parameter int CW = 32,
  parameter int CF = 12,
  parameter int DW = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  vct_pkg::cfg_t        cfg,
  output vct_pkg::ctl_t        ctl,
  output logic signed [DW+16:0] ax,
  output logic signed [DW+16:0] ay
);

  localparam int PRW = DW + 16;
  localparam int AW  = DW + 17;

  vct_pkg::kind_t       kind;
  logic                 point;
  logic                 inverse;
  logic                 bad;
  logic signed [17:0]   cx_px;
  logic signed [17:0]   cy_px;
  logic signed [DW-1:0] cxd;
  logic signed [DW-1:0] cyd;
  logic signed [DW-1:0] dx_next;
  logic signed [DW-1:0] dy_next;

  vct_pkg::ctl_t        s1_ctl;
  vct_pkg::ctl_t        s2_ctl;
  logic signed [DW-1:0] s1_dx;
  logic signed [DW-1:0] s1_dy;
  logic signed [PRW-1:0] s2_cdx;
  logic signed [PRW-1:0] s2_sdy;
  logic signed [PRW-1:0] s2_sdx;
  logic signed [PRW-1:0] s2_cdy;

  always_comb begin
    kind    = vct_pkg::kind_t'(in_kind);
    point   = vct_pkg::is_point(kind);
    inverse = vct_pkg::is_inverse(kind);
    bad     = (point && (cfg.width[15] || cfg.width == '0 ||
                         cfg.height[15] || cfg.height == '0)) ||
              (inverse && cfg.zoom == '0);
    cx_px   = vct_pkg::center_x2(cfg.origin[15:0], cfg.width);
    cy_px   = vct_pkg::center_x2(cfg.origin[31:16], cfg.height);
    cxd     = DW'(cx_px) <<< CF;
    cyd     = DW'(cy_px) <<< CF;
    if (inverse) begin
      dx_next = (DW'(in_x) <<< 1) - (point ? cxd : DW'(0));
      dy_next = (DW'(in_y) <<< 1) - (point ? cyd : DW'(0));
    end else begin
      dx_next = DW'(in_x) - (point ? DW'(cfg.cam_x) : DW'(0));
      dy_next = DW'(in_y) - (point ? DW'(cfg.cam_y) : DW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      ctl    <= '0;
    end else if (en) begin
      s1_ctl <= '{valid: in_valid, kind: kind, invalid: bad};
      s2_ctl <= s1_ctl;
      ctl    <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= dx_next;
      s1_dy  <= dy_next;
      s2_cdx <= cfg.rcos * s1_dx;
      s2_sdy <= cfg.rsin * s1_dy;
      s2_sdx <= cfg.rsin * s1_dx;
      s2_cdy <= cfg.rcos * s1_dy;
      if (vct_pkg::is_inverse(s2_ctl.kind)) begin
        ax <= AW'(s2_cdx) - AW'(s2_sdy);
        ay <= AW'(s2_sdx) + AW'(s2_cdy);
      end else begin
        ax <= AW'(s2_cdx) + AW'(s2_sdy);
        ay <= AW'(s2_cdy) - AW'(s2_sdx);
      end
    end
  end

endmodule

[sv/vct_div.sv]
// ----------------------------------------------------------------------------
// vct_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit and a side payload carried along.
// ----------------------------------------------------------------------------
module vct_div #(
  parameter int NW  = 68,
  parameter int DVW = 47,
  parameter int QB  = 34,
  parameter int SW  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [NW-1:0]   n_x,
  input  logic [NW-1:0]   n_y,
  input  logic [DVW-1:0]  d,
  input  logic [SW-1:0]   side_in,
  output logic [QB-1:0]   q_x,
  output logic [QB-1:0]   q_y,
  output logic            ovf_x,
  output logic            ovf_y,
  output logic [SW-1:0]   side_out
);

  localparam int XW = (NW > DVW) ? NW : DVW;

  logic [NW-1:0]  nin  [2];
  logic [DVW-1:0] rr   [QB+1][2];
  logic [QB-1:0]  nl   [QB+1][2];
  logic [QB-1:0]  qq   [QB+1][2];
  logic           ov   [QB+1][2];
  logic [SW-1:0]  sd   [QB+1];

  assign nin[0] = n_x;
  assign nin[1] = n_y;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ov[0][l] <= XW'(nin[l] >> QB) >= XW'(d);
        rr[0][l] <= (XW'(nin[l] >> QB) >= XW'(d)) ? '0 : DVW'(nin[l] >> QB);
        nl[0][l] <= nin[l][QB-1:0];
        qq[0][l] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0] <= '0;
    end else if (en) begin
      sd[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DVW:0] t    [2];
    logic         ge   [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]  = {rr[k-1][l], nl[k-1][l][QB-1]};
        ge[l] = t[l] >= {1'b0, d};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rr[k][l] <= ge[l] ? DVW'(t[l] - {1'b0, d}) : DVW'(t[l]);
          nl[k][l] <= nl[k-1][l] << 1;
          qq[k][l] <= {qq[k-1][l][QB-2:0], ge[l]};
          ov[k][l] <= ov[k-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k] <= '0;
      end else if (en) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  assign q_x      = qq[QB][0];
  assign q_y      = qq[QB][1];
  assign ovf_x    = ov[QB][0];
  assign ovf_y    = ov[QB][1];
  assign side_out = sd[QB];

endmodule

[sv/viewport_camera_transform.sv]
// ----------------------------------------------------------------------------
// viewport_camera_transform
// Fixed-point 2D screen/world transform of points and deltas.
//
//   channel  dir  handshake        beat payload
//   req      in   valid/ready      kind, in_x, in_y
//   rsp      out  valid/ready      out_x, out_y, invalid
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// One beat enters per cycle while the output is not stalled; every beat passes
// the COORD_WIDTH-independent stages and then the one-bit-per-stage quotient
// pipeline of the inverse path, whose depth follows max(COORD_WIDTH,32).
// Reset clears all valid bits and loads the register defaults.
// A stalled output beat freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module viewport_camera_transform #(
  parameter int COORD_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 12,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vct_pkg::CFG_DATA_W-1:0]      cfg_data,
  vct_in_if.sink                              req,
  vct_out_if.source                           rsp
);

  localparam int CW  = COORD_WIDTH;
  localparam int CF  = COORD_FRAC_BITS;
  localparam int TF  = TRIG_FRAC_BITS;
  localparam int MW  = (CW > 32) ? CW : 32;
  localparam int DW  = (MW + 2 > CF + 19) ? MW + 2 : CF + 19;
  localparam int AW  = DW + 17;
  localparam int NW  = ((AW + 16 > 32 + TF) ? AW + 16 : 32 + TF) + 1;
  localparam int QB  = MW + 2;
  localparam int DVW = 33 + TF;
  localparam int L   = AW / 2;
  localparam int HW  = AW - L;
  localparam int PW  = ((AW + 33 > CF + TF + 33) ? AW + 33 : CF + TF + 33) + 1;
  localparam int FQW = PW - TF - 15;
  localparam int CTW = $bits(vct_pkg::ctl_t);
  localparam int SW  = CTW + 2 + 2 * FQW;

  vct_pkg::cfg_t          cfg;
  logic                   en;
  vct_pkg::ctl_t          s3_ctl;
  logic signed [AW-1:0]   s3_ax;
  logic signed [AW-1:0]   s3_ay;
  logic [AW-1:0]          magx;
  logic [AW-1:0]          magy;

  vct_pkg::ctl_t          s4_ctl;
  logic [NW-1:0]          s4_nx;
  logic [NW-1:0]          s4_ny;
  logic                   s4_sx;
  logic                   s4_sy;
  logic [L+31:0]          s4_mlox;
  logic [L+31:0]          s4_mloy;
  logic signed [HW+32:0]  s4_mhix;
  logic signed [HW+32:0]  s4_mhiy;

  vct_pkg::ctl_t          s5_ctl;
  logic [NW-1:0]          s5_nx;
  logic [NW-1:0]          s5_ny;
  logic                   s5_sx;
  logic                   s5_sy;
  logic signed [PW-1:0]   s5_vx;
  logic signed [PW-1:0]   s5_vy;
  logic signed [17:0]     cx_px;
  logic signed [17:0]     cy_px;
  logic                   s4_point;

  vct_pkg::ctl_t          s6_ctl;
  logic [NW-1:0]          s6_nx;
  logic [NW-1:0]          s6_ny;
  logic                   s6_negx;
  logic                   s6_negy;
  logic [FQW-1:0]         s6_fqx;
  logic [FQW-1:0]         s6_fqy;
  logic [PW-1:0]          vmx;
  logic [PW-1:0]          vmy;

  logic [QB-1:0]          q_x;
  logic [QB-1:0]          q_y;
  logic                   ovf_x;
  logic                   ovf_y;
  logic [SW-1:0]          side_out;
  vct_pkg::ctl_t          d_ctl;
  logic                   d_negx;
  logic                   d_negy;
  logic [FQW-1:0]         d_fqx;
  logic [FQW-1:0]         d_fqy;

  logic signed [QB+1:0]   isx;
  logic signed [QB+1:0]   isy;
  logic signed [FQW:0]    fsx;
  logic signed [FQW:0]    fsy;
  logic [CW-1:0]          ox_next;
  logic [CW-1:0]          oy_next;
  logic                   d_point;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  vct_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  vct_front #(.CW(CW), .CF(CF), .DW(DW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_x     (req.in_x),
    .in_y     (req.in_y),
    .cfg      (cfg),
    .ctl      (s3_ctl),
    .ax       (s3_ax),
    .ay       (s3_ay)
  );

  always_comb begin
    magx     = s3_ax[AW-1] ? AW'(-s3_ax) : AW'(s3_ax);
    magy     = s3_ay[AW-1] ? AW'(-s3_ay) : AW'(s3_ay);
    cx_px    = vct_pkg::center_x2(cfg.origin[15:0], cfg.width);
    cy_px    = vct_pkg::center_x2(cfg.origin[31:16], cfg.height);
    s4_point = vct_pkg::is_point(s4_ctl.kind);
    vmx      = s5_vx[PW-1] ? PW'(-s5_vx) : PW'(s5_vx);
    vmy      = s5_vy[PW-1] ? PW'(-s5_vy) : PW'(s5_vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl <= '0;
      s5_ctl <= '0;
      s6_ctl <= '0;
    end else if (en) begin
      s4_ctl <= s3_ctl;
      s5_ctl <= s4_ctl;
      s6_ctl <= s5_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nx   <= (NW'(magx) << 16) + (NW'(cfg.zoom) << TF);
      s4_ny   <= (NW'(magy) << 16) + (NW'(cfg.zoom) << TF);
      s4_sx   <= s3_ax[AW-1];
      s4_sy   <= s3_ay[AW-1];
      s4_mlox <= s3_ax[L-1:0] * cfg.zoom;
      s4_mloy <= s3_ay[L-1:0] * cfg.zoom;
      s4_mhix <= $signed(s3_ax[AW-1:L]) * $signed({1'b0, cfg.zoom});
      s4_mhiy <= $signed(s3_ay[AW-1:L]) * $signed({1'b0, cfg.zoom});

      s5_nx   <= s4_nx;
      s5_ny   <= s4_ny;
      s5_sx   <= s4_sx;
      s5_sy   <= s4_sy;
      s5_vx   <= (PW'(s4_mhix) << L) + PW'(s4_mlox) +
                 (s4_point ? (PW'(cx_px) << (CF + TF + 15)) : PW'(0));
      s5_vy   <= (PW'(s4_mhiy) << L) + PW'(s4_mloy) +
                 (s4_point ? (PW'(cy_px) << (CF + TF + 15)) : PW'(0));

      s6_nx   <= s5_nx;
      s6_ny   <= s5_ny;
      s6_fqx  <= FQW'((vmx + (PW'(1) << (TF + 15))) >> (TF + 16));
      s6_fqy  <= FQW'((vmy + (PW'(1) << (TF + 15))) >> (TF + 16));
      if (vct_pkg::is_inverse(s5_ctl.kind)) begin
        s6_negx <= s5_sx;
        s6_negy <= s5_sy;
      end else begin
        s6_negx <= s5_vx[PW-1];
        s6_negy <= s5_vy[PW-1];
      end
    end
  end

  vct_div #(.NW(NW), .DVW(DVW), .QB(QB), .SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .n_x      (s6_nx),
    .n_y      (s6_ny),
    .d        (DVW'(cfg.zoom) << (TF + 1)),
    .side_in  ({s6_ctl, s6_negx, s6_negy, s6_fqx, s6_fqy}),
    .q_x      (q_x),
    .q_y      (q_y),
    .ovf_x    (ovf_x),
    .ovf_y    (ovf_y),
    .side_out (side_out)
  );

  always_comb begin
    {d_ctl, d_negx, d_negy, d_fqx, d_fqy} = side_out;
    d_point = vct_pkg::is_point(d_ctl.kind);
    isx = (d_negx ? -(QB+2)'(q_x) : (QB+2)'(q_x)) +
          (d_point ? (QB+2)'(cfg.cam_x) : (QB+2)'(0));
    isy = (d_negy ? -(QB+2)'(q_y) : (QB+2)'(q_y)) +
          (d_point ? (QB+2)'(cfg.cam_y) : (QB+2)'(0));
    fsx = d_negx ? -(FQW+1)'(d_fqx) : (FQW+1)'(d_fqx);
    fsy = d_negy ? -(FQW+1)'(d_fqy) : (FQW+1)'(d_fqy);

    if (d_ctl.invalid) begin
      ox_next = '0;
      oy_next = '0;
    end else if (vct_pkg::is_inverse(d_ctl.kind)) begin
      if (ovf_x || !(&isx[QB+1:CW-1] || ~|isx[QB+1:CW-1])) begin
        ox_next = {d_negx, {(CW-1){~d_negx}}};
      end else begin
        ox_next = isx[CW-1:0];
      end
      if (ovf_y || !(&isy[QB+1:CW-1] || ~|isy[QB+1:CW-1])) begin
        oy_next = {d_negy, {(CW-1){~d_negy}}};
      end else begin
        oy_next = isy[CW-1:0];
      end
    end else begin
      if (&fsx[FQW:CW-1] || ~|fsx[FQW:CW-1]) begin
        ox_next = fsx[CW-1:0];
      end else begin
        ox_next = {fsx[FQW], {(CW-1){~fsx[FQW]}}};
      end
      if (&fsy[FQW:CW-1] || ~|fsy[FQW:CW-1]) begin
        oy_next = fsy[CW-1:0];
      end else begin
        oy_next = {fsy[FQW], {(CW-1){~fsy[FQW]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.out_x   <= ox_next;
      rsp.out_y   <= oy_next;
      rsp.invalid <= d_ctl.invalid;
    end
  end

endmodule

[sv/vct_chk.sv]
// ----------------------------------------------------------------------------
// vct_chk
// Port-level checks for the viewport camera transform, bound to the top level.
// ----------------------------------------------------------------------------
module vct_chk #(
  parameter int CW = 32
) (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input logic          rsp_invalid,
  input logic [CW-1:0] rsp_out_x,
  input logic [CW-1:0] rsp_out_y
);

  // A beat forced to zero must really carry zeros.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_invalid |-> rsp_out_x == '0 && rsp_out_y == '0)
    else $error("invalid beat with nonzero coordinates");

  // A stalled output holds back the input side.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input accepted while output stalled");

  // An idle output always lets the input in.
  a_open: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input blocked with empty output");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y))
    else $error("stalled output beat changed");

endmodule

bind viewport_camera_transform vct_chk #(.CW(COORD_WIDTH)) u_vct_chk (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_invalid (rsp.invalid),
  .rsp_out_x   (rsp.out_x),
  .rsp_out_y   (rsp.out_y)
);
